// ----- rtl/cceul_pkg.sv -----
package cceul_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_WIDTH       = 16;

    localparam int FULL_TURN      = 11520;
    localparam int QUARTER_TURN   = 2880;
    localparam int SENTINEL_LIMIT = -5760;

    localparam int ANG_W  = 16;
    localparam int FOLD_W = 14;
    localparam int R_W    = 12;
    localparam int NUM_W  = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = NUM_W + 27;

    localparam int RECIP_SHIFT = 38;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + QUARTER_TURN - 1) / QUARTER_TURN;

    localparam int SV_W   = SINE_WIDTH + 1;
    localparam int OFF_W  = 19;
    localparam int ROT1_W = 21;
    localparam int ROT2_W = 22;
    localparam int ROT3_W = 23;
    localparam int ROUND_BIAS = 1 << (SINE_WIDTH - 2);

    localparam int POS_W  = 32;
    localparam int OANG_W = 16;
    localparam int ZOOM_W = 16;

    localparam int PIPE_DEPTH = 12;
    localparam int PAY_DEPTH  = 11;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 160;

    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_OFFSET_BACK    = 3'd0;
    localparam logic [2:0] REG_OFFSET_RIGHT   = 3'd1;
    localparam logic [2:0] REG_OFFSET_UP      = 3'd2;
    localparam logic [2:0] REG_ROLL_OFFSET    = 3'd3;
    localparam logic [2:0] REG_PITCH_OFFSET   = 3'd4;
    localparam logic [2:0] REG_HEADING_OFFSET = 3'd5;
    localparam logic [2:0] REG_ZOOM_FACTOR    = 3'd6;
    localparam logic [15:0] ZOOM_RESET = 16'd256;

    typedef struct packed {
        logic signed [OFF_W-1:0]  offset_back;
        logic signed [OFF_W-1:0]  offset_right;
        logic signed [OFF_W-1:0]  offset_up;
        logic signed [OANG_W-1:0] roll_offset;
        logic signed [OANG_W-1:0] pitch_offset;
        logic signed [OANG_W-1:0] heading_offset;
        logic [ZOOM_W-1:0]        zoom_factor;
    } t_cfg;

    typedef struct packed {
        logic signed [SV_W-1:0] c1;
        logic signed [SV_W-1:0] s1;
        logic signed [SV_W-1:0] c2;
        logic signed [SV_W-1:0] s2;
        logic signed [SV_W-1:0] c3;
        logic signed [SV_W-1:0] s3;
    } t_trig;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [OANG_W-1:0]       roll;
        logic [OANG_W-1:0]       pitch;
        logic [OANG_W-1:0]       heading;
    } t_pay;

    typedef logic [SINE_TABLE_DEPTH:0][SINE_WIDTH-1:0] t_sine_tab;

    localparam int unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    function automatic t_sine_tab f_build();
        t_sine_tab      tab;
        logic [63:0]    x;
        logic [63:0]    x2;
        logic [63:0]    term;
        logic [63:0]    v;
        logic [63:0]    one;
        longint         sum;
        one = 64'd1 << (SINE_WIDTH - 1);
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'd1686629713 * 64'(i)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k-1]);
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (64'(sum) * one + (64'd1 << 29)) >> 30;
            if (v > one) begin
                v = one;
            end
            tab[i] = v[SINE_WIDTH-1:0];
        end
        return tab;
    endfunction

    function automatic logic [OANG_W-1:0] f_angle_out(
        input logic signed [16:0]        veh,
        input logic signed [OANG_W-1:0]  off
    );
        logic signed [17:0] s;
        logic [OANG_W-1:0]  res;
        s = 18'(veh) + 18'(off);
        if (off < 16'(SENTINEL_LIMIT)) begin
            res = '0;
        end else if (s > 18'sd32767) begin
            res = 16'h7FFF;
        end else if (s < -18'sd32768) begin
            res = 16'h8000;
        end else begin
            res = s[OANG_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/chase_camera_euler_rotate.sv -----
// Chase camera pose generator.
// Slave stream (i_s_*): one vehicle pose per word. Master stream (o_m_*):
// one camera pose per accepted word, in order. APB port: offsets, angle
// offsets and zoom, which the user must write only while no pose is in
// flight; the block itself does not enforce this. Throughput: one word per
// cycle while the output is not stalled, with six quarter-wave sine ROMs
// (one per sine or cosine) and a twelve-stage pipeline of lookups,
// multiplies and rounding adds.
// Reset: all valid bits clear, the pipeline empties, the registers return to
// zero offsets and zoom 1.0.
// Stall: while o_m_tvalid is high and i_m_tready low, the whole pipeline
// holds and o_s_tready drops; nothing is lost or repeated. A waiting result
// is taken and a new word accepted in the same cycle.
module chase_camera_euler_rotate (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // vehicle_x, vehicle_y, vehicle_z, vehicle_roll, vehicle_pitch, vehicle_heading
    input  logic [cceul_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // camera_x, camera_y, camera_z, camera_roll, camera_pitch, camera_heading,
    // camera_zoom
    output logic [cceul_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cceul_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import cceul_pkg::*;

    t_cfg                   w_cfg;
    t_trig                  w_trig;
    logic                   w_en;
    logic [PIPE_DEPTH:1]    r_vld;
    t_pay                   r_pay [PAY_DEPTH];
    t_pay                   n_pay;

    logic signed [POS_W-1:0]  w_px, w_py, w_pz;
    logic signed [13:0]       w_roll;
    logic signed [12:0]       w_pitch;
    logic [13:0]              w_hdg;
    logic signed [16:0]       w_roll_e, w_pitch_e, w_hdg_e;

    logic signed [ROT3_W-1:0] w_xw, w_zw;
    logic signed [ROT2_W-1:0] w_yp;
    logic signed [POS_W:0]    n_sx, n_sy, n_sz;

    logic [POS_W-1:0]  r_cx, r_cy, r_cz;
    logic [OANG_W-1:0] r_croll, r_cpitch, r_chdg;
    logic [ZOOM_W-1:0] r_czoom;

    assign w_px    = i_s_tdata[31:0];
    assign w_py    = i_s_tdata[63:32];
    assign w_pz    = i_s_tdata[95:64];
    assign w_roll  = i_s_tdata[109:96];
    assign w_pitch = i_s_tdata[122:110];
    assign w_hdg   = i_s_tdata[136:123];

    assign w_roll_e  = 17'(w_roll);
    assign w_pitch_e = 17'(w_pitch);
    assign w_hdg_e   = {3'b000, w_hdg};

    assign w_en       = !r_vld[PIPE_DEPTH] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[PIPE_DEPTH];
    assign o_m_tdata  = {r_czoom, r_chdg, r_cpitch, r_croll, r_cz, r_cy, r_cx};

    cceul_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cceul_sine u_s1 (.i_clk(i_clk), .i_en(w_en),
        .i_angle(w_roll_e[ANG_W-1:0]), .o_value(w_trig.s1));
    cceul_sine u_c1 (.i_clk(i_clk), .i_en(w_en),
        .i_angle(ANG_W'(w_roll_e + 17'(QUARTER_TURN))), .o_value(w_trig.c1));
    cceul_sine u_s2 (.i_clk(i_clk), .i_en(w_en),
        .i_angle(w_pitch_e[ANG_W-1:0]), .o_value(w_trig.s2));
    cceul_sine u_c2 (.i_clk(i_clk), .i_en(w_en),
        .i_angle(ANG_W'(w_pitch_e + 17'(QUARTER_TURN))), .o_value(w_trig.c2));
    cceul_sine u_s3 (.i_clk(i_clk), .i_en(w_en),
        .i_angle(w_hdg_e[ANG_W-1:0]), .o_value(w_trig.s3));
    cceul_sine u_c3 (.i_clk(i_clk), .i_en(w_en),
        .i_angle(ANG_W'(w_hdg_e + 17'(QUARTER_TURN))), .o_value(w_trig.c3));

    cceul_rot u_rot (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cfg  (w_cfg),
        .i_trig (w_trig),
        .o_xw   (w_xw),
        .o_yp   (w_yp),
        .o_zw   (w_zw)
    );

    always_comb begin
        n_pay.px      = w_px;
        n_pay.py      = w_py;
        n_pay.pz      = w_pz;
        n_pay.roll    = f_angle_out(w_roll_e, w_cfg.roll_offset);
        n_pay.pitch   = f_angle_out(w_pitch_e, w_cfg.pitch_offset);
        n_pay.heading = f_angle_out(w_hdg_e, w_cfg.heading_offset);

        n_sx = (POS_W+1)'(r_pay[PAY_DEPTH-1].px) + (POS_W+1)'(w_xw);
        n_sy = (POS_W+1)'(r_pay[PAY_DEPTH-1].py) + (POS_W+1)'(w_yp);
        n_sz = (POS_W+1)'(r_pay[PAY_DEPTH-1].pz) + (POS_W+1)'(w_zw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-1:1], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pay[0] <= n_pay;
            for (int k = 1; k < PAY_DEPTH; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
            r_cx <= (n_sx[POS_W] != n_sx[POS_W-1]) ?
                    {n_sx[POS_W], {(POS_W-1){!n_sx[POS_W]}}} : n_sx[POS_W-1:0];
            r_cy <= (n_sy[POS_W] != n_sy[POS_W-1]) ?
                    {n_sy[POS_W], {(POS_W-1){!n_sy[POS_W]}}} : n_sy[POS_W-1:0];
            r_cz <= (n_sz[POS_W] != n_sz[POS_W-1]) ?
                    {n_sz[POS_W], {(POS_W-1){!n_sz[POS_W]}}} : n_sz[POS_W-1:0];
            r_croll  <= r_pay[PAY_DEPTH-1].roll;
            r_cpitch <= r_pay[PAY_DEPTH-1].pitch;
            r_chdg   <= r_pay[PAY_DEPTH-1].heading;
            r_czoom  <= w_cfg.zoom_factor;
        end
    end

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_DEPTH] && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while output stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_roll_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_cfg.roll_offset < 16'(SENTINEL_LIMIT)))
        |-> (o_m_tdata[111:96] == 16'd0))
        else $error("sentinel roll offset gave nonzero roll");

    a_zoom_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[159:144] == w_cfg.zoom_factor))
        else $error("zoom differs from register");
`endif

endmodule

// ----- rtl/cceul_cfg.sv -----
module cceul_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cceul_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output cceul_pkg::t_cfg              o_cfg
);
    import cceul_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_back    <= '0;
            r_cfg.offset_right   <= '0;
            r_cfg.offset_up      <= '0;
            r_cfg.roll_offset    <= '0;
            r_cfg.pitch_offset   <= '0;
            r_cfg.heading_offset <= '0;
            r_cfg.zoom_factor    <= ZOOM_RESET;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            case (w_idx)
                REG_OFFSET_BACK:    r_cfg.offset_back    <= pwdata[OFF_W-1:0];
                REG_OFFSET_RIGHT:   r_cfg.offset_right   <= pwdata[OFF_W-1:0];
                REG_OFFSET_UP:      r_cfg.offset_up      <= pwdata[OFF_W-1:0];
                REG_ROLL_OFFSET:    r_cfg.roll_offset    <= pwdata[OANG_W-1:0];
                REG_PITCH_OFFSET:   r_cfg.pitch_offset   <= pwdata[OANG_W-1:0];
                REG_HEADING_OFFSET: r_cfg.heading_offset <= pwdata[OANG_W-1:0];
                REG_ZOOM_FACTOR:    r_cfg.zoom_factor    <= pwdata[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (w_idx)
                REG_OFFSET_BACK:    prdata = 32'(unsigned'(r_cfg.offset_back));
                REG_OFFSET_RIGHT:   prdata = 32'(unsigned'(r_cfg.offset_right));
                REG_OFFSET_UP:      prdata = 32'(unsigned'(r_cfg.offset_up));
                REG_ROLL_OFFSET:    prdata = 32'(unsigned'(r_cfg.roll_offset));
                REG_PITCH_OFFSET:   prdata = 32'(unsigned'(r_cfg.pitch_offset));
                REG_HEADING_OFFSET: prdata = 32'(unsigned'(r_cfg.heading_offset));
                REG_ZOOM_FACTOR:    prdata = 32'(r_cfg.zoom_factor);
                default:            prdata = '0;
            endcase
        end
    end

endmodule

// ----- rtl/cceul_sine.sv -----
module cceul_sine (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [cceul_pkg::ANG_W-1:0]  i_angle,
    output logic signed [cceul_pkg::SV_W-1:0]   o_value
);
    import cceul_pkg::*;

    localparam t_sine_tab SINE_ROM = f_build();

    logic [FOLD_W-1:0]      r_fold;
    logic [1:0]             r_q2;
    logic [NUM_W-1:0]       r_num;
    logic [1:0]             r_q3;
    logic [IDX_W-1:0]       r_idx;
    logic [SINE_WIDTH-1:0]  r_rom;
    logic                   r_neg;
    logic signed [SV_W-1:0] r_val;

    logic signed [ANG_W-1:0] n_fold;
    logic [1:0]              n_q;
    logic [FOLD_W-1:0]       n_rem;
    logic [PROD_W-1:0]       n_prod;
    logic [IDX_W-1:0]        n_addr;
    logic [SV_W-1:0]         n_ext;

    always_comb begin
        if (i_angle < 0) begin
            n_fold = i_angle + 16'(FULL_TURN);
        end else if (i_angle >= 16'(FULL_TURN)) begin
            n_fold = i_angle - 16'(FULL_TURN);
        end else begin
            n_fold = i_angle;
        end

        if (r_fold >= FOLD_W'(3 * QUARTER_TURN)) begin
            n_q   = 2'd3;
            n_rem = r_fold - FOLD_W'(3 * QUARTER_TURN);
        end else if (r_fold >= FOLD_W'(2 * QUARTER_TURN)) begin
            n_q   = 2'd2;
            n_rem = r_fold - FOLD_W'(2 * QUARTER_TURN);
        end else if (r_fold >= FOLD_W'(QUARTER_TURN)) begin
            n_q   = 2'd1;
            n_rem = r_fold - FOLD_W'(QUARTER_TURN);
        end else begin
            n_q   = 2'd0;
            n_rem = r_fold;
        end

        n_prod = PROD_W'(r_num) * PROD_W'(RECIP);
        n_addr = r_q3[0] ? (IDX_W'(SINE_TABLE_DEPTH) - r_idx) : r_idx;
        n_ext  = {1'b0, r_rom};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold <= n_fold[FOLD_W-1:0];
            r_q2   <= n_q;
            r_num  <= NUM_W'(n_rem[R_W-1:0]) * NUM_W'(SINE_TABLE_DEPTH)
                      + NUM_W'(QUARTER_TURN / 2);
            r_q3   <= r_q2;
            r_idx  <= n_prod[RECIP_SHIFT +: IDX_W];
            r_rom  <= SINE_ROM[n_addr];
            r_neg  <= r_q3[1];
            r_val  <= r_neg ? -signed'(n_ext) : signed'(n_ext);
        end
    end

    assign o_value = r_val;

endmodule

// ----- rtl/cceul_rot.sv -----
module cceul_rot (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  cceul_pkg::t_cfg                      i_cfg,
    input  cceul_pkg::t_trig                     i_trig,
    output logic signed [cceul_pkg::ROT3_W-1:0]  o_xw,
    output logic signed [cceul_pkg::ROT2_W-1:0]  o_yp,
    output logic signed [cceul_pkg::ROT3_W-1:0]  o_zw
);
    import cceul_pkg::*;

    localparam int PR1_W = OFF_W + SV_W;
    localparam int PR2_W = ROT1_W + SV_W;
    localparam int PR3_W = ROT2_W + SV_W;

    t_trig r_trig6;
    t_trig r_trig7;
    t_trig r_trig8;
    t_trig r_trig9;

    logic signed [PR1_W-1:0]  r_p_rc, r_p_us, r_p_uc, r_p_rs;
    logic signed [ROT1_W-1:0] r_xr7, r_yr7, r_zr7, r_xr8, r_xr9;
    logic signed [PR2_W-1:0]  r_p_yc, r_p_zs, r_p_zc, r_p_ys;
    logic signed [ROT2_W-1:0] r_yp9, r_zp9, r_yp10, r_yp11;
    logic signed [PR3_W-1:0]  r_p_xc, r_p_zs3, r_p_zc3, r_p_xs;
    logic signed [ROT3_W-1:0] r_xw11, r_zw11;

    logic signed [PR1_W:0] n_xr, n_yr;
    logic signed [PR2_W:0] n_yp, n_zp;
    logic signed [PR3_W:0] n_xw, n_zw;

    always_comb begin
        n_xr = (PR1_W+1)'(r_p_rc) + (PR1_W+1)'(r_p_us) + (PR1_W+1)'(ROUND_BIAS);
        n_yr = (PR1_W+1)'(r_p_uc) - (PR1_W+1)'(r_p_rs) + (PR1_W+1)'(ROUND_BIAS);
        n_yp = (PR2_W+1)'(r_p_yc) - (PR2_W+1)'(r_p_zs) + (PR2_W+1)'(ROUND_BIAS);
        n_zp = (PR2_W+1)'(r_p_zc) + (PR2_W+1)'(r_p_ys) + (PR2_W+1)'(ROUND_BIAS);
        n_xw = (PR3_W+1)'(r_p_xc) - (PR3_W+1)'(r_p_zs3) + (PR3_W+1)'(ROUND_BIAS);
        n_zw = (PR3_W+1)'(r_p_zc3) + (PR3_W+1)'(r_p_xs) + (PR3_W+1)'(ROUND_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig6 <= i_trig;
            r_trig7 <= r_trig6;
            r_trig8 <= r_trig7;
            r_trig9 <= r_trig8;

            r_p_rc <= i_cfg.offset_right * i_trig.c1;
            r_p_us <= i_cfg.offset_up * i_trig.s1;
            r_p_uc <= i_cfg.offset_up * i_trig.c1;
            r_p_rs <= i_cfg.offset_right * i_trig.s1;

            r_xr7 <= n_xr[SINE_WIDTH-1 +: ROT1_W];
            r_yr7 <= n_yr[SINE_WIDTH-1 +: ROT1_W];
            r_zr7 <= ROT1_W'(i_cfg.offset_back);

            r_p_yc <= r_yr7 * r_trig7.c2;
            r_p_zs <= r_zr7 * r_trig7.s2;
            r_p_zc <= r_zr7 * r_trig7.c2;
            r_p_ys <= r_yr7 * r_trig7.s2;
            r_xr8  <= r_xr7;

            r_yp9 <= n_yp[SINE_WIDTH-1 +: ROT2_W];
            r_zp9 <= n_zp[SINE_WIDTH-1 +: ROT2_W];
            r_xr9 <= r_xr8;

            r_p_xc  <= ROT2_W'(r_xr9) * r_trig9.c3;
            r_p_zs3 <= r_zp9 * r_trig9.s3;
            r_p_zc3 <= r_zp9 * r_trig9.c3;
            r_p_xs  <= ROT2_W'(r_xr9) * r_trig9.s3;
            r_yp10  <= r_yp9;

            r_xw11 <= n_xw[SINE_WIDTH-1 +: ROT3_W];
            r_zw11 <= n_zw[SINE_WIDTH-1 +: ROT3_W];
            r_yp11 <= r_yp10;
        end
    end

    assign o_xw = r_xw11;
    assign o_yp = r_yp11;
    assign o_zw = r_zw11;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import cceul_pkg::*;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] heading;
        logic [15:0] zoom;
    } t_pose;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    chase_camera_euler_rotate DUT (.*);

    longint  sine_rom [SINE_TABLE_DEPTH+1];
    longint  cfg_back, cfg_right, cfg_up, cfg_roll, cfg_pitch, cfg_hdg;
    longint  cfg_zoom;
    t_pose   pose_q [$];
    int      fails;
    bit      calm;
    int      hold_off;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void build_rom();
        longint unsigned x, x2, term, v, one;
        longint sum;
        one = 64'd1 << (SINE_WIDTH - 1);
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x = (64'd1686629713 * i) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k & 1) sum -= term; else sum += term;
            end
            if (sum < 0) sum = 0;
            v = (longint'(sum) * one + (64'd1 << 29)) >> 30;
            if (v > one) v = one;
            sine_rom[i] = v;
        end
    endfunction

    function automatic longint sine_at(longint ang);
        longint a, q, r, i, v;
        a = ang % FULL_TURN;
        if (a < 0) a += FULL_TURN;
        q = a / QUARTER_TURN;
        r = a % QUARTER_TURN;
        i = (r * SINE_TABLE_DEPTH + QUARTER_TURN / 2) / QUARTER_TURN;
        if (i > SINE_TABLE_DEPTH) i = SINE_TABLE_DEPTH;
        v = q[0] ? sine_rom[SINE_TABLE_DEPTH - i] : sine_rom[i];
        return (q >= 2) ? -v : v;
    endfunction

    function automatic longint round_q15(longint v);
        return (v + (64'sd1 <<< (SINE_WIDTH - 2))) >>> (SINE_WIDTH - 1);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [15:0] cam_angle(longint veh, longint off);
        if (off < SENTINEL_LIMIT) return 16'd0;
        return 16'(clamp(veh + off, -32768, 32767));
    endfunction

    function automatic t_pose camera_pose(logic [IN_DATA_W-1:0] d);
        longint px, py, pz, rl, pt, hd, s1, c1, s2, c2, s3, c3;
        longint xr, yr, yp, zp, xw, zw;
        t_pose p;
        px = longint'(signed'(d[31:0]));
        py = longint'(signed'(d[63:32]));
        pz = longint'(signed'(d[95:64]));
        rl = longint'(signed'(d[109:96]));
        pt = longint'(signed'(d[122:110]));
        hd = longint'(d[136:123]);
        s1 = sine_at(rl); c1 = sine_at(rl + QUARTER_TURN);
        s2 = sine_at(pt); c2 = sine_at(pt + QUARTER_TURN);
        s3 = sine_at(hd); c3 = sine_at(hd + QUARTER_TURN);
        xr = round_q15(cfg_right * c1 + cfg_up * s1);
        yr = round_q15(cfg_up * c1 - cfg_right * s1);
        yp = round_q15(yr * c2 - cfg_back * s2);
        zp = round_q15(cfg_back * c2 + yr * s2);
        xw = round_q15(xr * c3 - zp * s3);
        zw = round_q15(zp * c3 + xr * s3);
        p.px = 32'(clamp(px + xw, -64'sd2147483648, 64'sd2147483647));
        p.py = 32'(clamp(py + yp, -64'sd2147483648, 64'sd2147483647));
        p.pz = 32'(clamp(pz + zw, -64'sd2147483648, 64'sd2147483647));
        p.roll = cam_angle(rl, cfg_roll);
        p.pitch = cam_angle(pt, cfg_pitch);
        p.heading = cam_angle(hd, cfg_hdg);
        p.zoom = 16'(cfg_zoom);
        return p;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = PADDR_W'({idx, 2'b00}); pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_OFFSET_BACK:    cfg_back  = longint'(signed'(val[18:0]));
            REG_OFFSET_RIGHT:   cfg_right = longint'(signed'(val[18:0]));
            REG_OFFSET_UP:      cfg_up    = longint'(signed'(val[18:0]));
            REG_ROLL_OFFSET:    cfg_roll  = longint'(signed'(val[15:0]));
            REG_PITCH_OFFSET:   cfg_pitch = longint'(signed'(val[15:0]));
            REG_HEADING_OFFSET: cfg_hdg   = longint'(signed'(val[15:0]));
            REG_ZOOM_FACTOR:    cfg_zoom  = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_pose_config(int b, int r, int u, int ro, int po, int ho, int z);
        apb_write(REG_OFFSET_BACK, b);
        apb_write(REG_OFFSET_RIGHT, r);
        apb_write(REG_OFFSET_UP, u);
        apb_write(REG_ROLL_OFFSET, ro);
        apb_write(REG_PITCH_OFFSET, po);
        apb_write(REG_HEADING_OFFSET, ho);
        apb_write(REG_ZOOM_FACTOR, z);
    endtask

    task automatic send_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [13:0] rl, logic [12:0] pt, logic [13:0] hd);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[136:0] = {hd, pt, rl, z, y, x};
        while (!calm && $urandom_range(99) < 11) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pose_q.push_back(camera_pose(d));
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain_poses();
        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
    endtask

    task automatic send_random_pose(int mode);
        logic [31:0] x, y, z;
        x = $urandom; y = $urandom; z = $urandom;
        if (mode == 0) begin
            send_pose(x, y, z, 14'($urandom_range(11520) - 5760),
                      13'($urandom_range(5760) - 2880), 14'($urandom_range(11520)));
        end else begin
            send_pose(x, y, z, 14'($urandom), 13'($urandom), 14'($urandom));
        end
    endtask

    task automatic test_directed();
        set_pose_config(256000, -256000, 100000, 11520, -32000, -5760, 65535);
        send_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFF00, 14'sd5760, 13'sd2880, 14'd11520);
        send_pose(32'h80000000, 32'h7FFFFFFF, 32'h80000100, -14'sd5760, -13'sd2880, 14'd0);
        send_pose(0, 0, 0, 0, 0, 14'd2880);
        send_pose(0, 0, 0, 14'h1FFF, 13'h0FFF, 14'h3FFF);
        send_pose(0, 0, 0, 14'h2000, 13'h1000, 14'd5760);
        drain_poses();
        set_pose_config(-256000, 256000, -256000, -32000, 11520, 11520, 0);
        send_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 14'sd1440, 13'sd1440, 14'd8640);
        send_pose(32'h80000000, 32'h80000000, 32'h80000000, -14'sd1440, -13'sd1440, 14'd1);
        send_pose(1, 2, 3, 14'sd2880, 13'sd2879, 14'd11519);
        drain_poses();
        set_pose_config(19'h7FFFF, 19'h40000, 19'h3FFFF, 16'h8000, 16'h7FFF, -5761, 256);
        send_pose(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 14'sd5000, -13'sd100, 14'd7000);
        send_pose(32'hFFFFFFFF, 0, 32'hAAAAAAAA, -14'sd5000, 13'sd100, 14'd100);
        drain_poses();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++) begin
            set_pose_config($urandom_range(512000) - 256000, $urandom_range(512000) - 256000,
                            $urandom_range(512000) - 256000, $urandom_range(43520) - 32000,
                            $urandom_range(43520) - 32000, $urandom_range(43520) - 32000,
                            $urandom_range(65535));
            calm = (ph == 3);
            for (int n = 0; n < 250; n++) send_random_pose($urandom_range(9) == 0);
            calm = 1'b0;
            drain_poses();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        for (int n = 0; n < 60; n++) send_random_pose(0);
        drain_poses();
    endtask

    initial begin
        calm = 1'b0; hold_off = 0; fails = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_back = 0; cfg_right = 0; cfg_up = 0; cfg_roll = 0; cfg_pitch = 0;
        cfg_hdg = 0; cfg_zoom = 256;
        build_rom();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int n = 0; n < 5; n++) send_random_pose(0);
        drain_poses();
        test_directed();
        test_random();
        test_backpressure();
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        t_pose got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.px      = o_m_tdata[31:0];
            got.py      = o_m_tdata[63:32];
            got.pz      = o_m_tdata[95:64];
            got.roll    = o_m_tdata[111:96];
            got.pitch   = o_m_tdata[127:112];
            got.heading = o_m_tdata[143:128];
            got.zoom    = o_m_tdata[159:144];
            if (pose_q.size() == 0) begin
                $error("unexpected camera pose %h", got);
                fails++;
            end else begin
                want = pose_q.pop_front();
                if (got.px != want.px) begin
                    $error("camera_x exp %h got %h", want.px, got.px); fails++;
                end
                if (got.py != want.py) begin
                    $error("camera_y exp %h got %h", want.py, got.py); fails++;
                end
                if (got.pz != want.pz) begin
                    $error("camera_z exp %h got %h", want.pz, got.pz); fails++;
                end
                if (got.roll != want.roll) begin
                    $error("camera_roll exp %h got %h", want.roll, got.roll); fails++;
                end
                if (got.pitch != want.pitch) begin
                    $error("camera_pitch exp %h got %h", want.pitch, got.pitch); fails++;
                end
                if (got.heading != want.heading) begin
                    $error("camera_heading exp %h got %h", want.heading, got.heading);
                    fails++;
                end
                if (got.zoom != want.zoom) begin
                    $error("camera_zoom exp %h got %h", want.zoom, got.zoom); fails++;
                end
            end
        end
    end

    initial begin
        #800000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/cceul_pkg.sv
rtl/cceul_cfg.sv
rtl/cceul_sine.sv
rtl/cceul_rot.sv
rtl/chase_camera_euler_rotate.sv
tb/sv/tb_top.sv
